/* rtl/bir_pkg.sv */
// Shared widths, register indexes and the controller state type of the bilinear resize unit.
package bir_pkg;

    localparam int PIX_W  = 8;
    localparam int SCOORD_W = 8;
    localparam int DCOORD_W = 10;
    localparam int SSIZE_W = 9;
    localparam int DSIZE_W = 11;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_HEIGHT = 2'd3;

    localparam logic [SSIZE_W-1:0] SSIZE_RESET = 9'd256;
    localparam logic [DSIZE_W-1:0] DSIZE_RESET = 11'd256;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef enum logic [11:0] {
        S_IDLE = 12'b0000_0000_0001,
        S_MAP  = 12'b0000_0000_0010,
        S_DIV  = 12'b0000_0000_0100,
        S_RD0  = 12'b0000_0000_1000,
        S_RD1  = 12'b0000_0001_0000,
        S_RD2  = 12'b0000_0010_0000,
        S_RD3  = 12'b0000_0100_0000,
        S_RD4  = 12'b0000_1000_0000,
        S_BLH0 = 12'b0001_0000_0000,
        S_BLH1 = 12'b0010_0000_0000,
        S_BLV  = 12'b0100_0000_0000,
        S_FIN  = 12'b1000_0000_0000
    } state_t;

    typedef struct packed {
        logic start;
        logic done;
    } div_ctrl_t;

endpackage

/* rtl/bir_divider.sv */
// Restoring divider, two quotient bits per cycle, giving integer part and fraction together.
module bir_divider #(
    parameter int NUM_W  = 19,
    parameter int DEN_W  = 11,
    parameter int FRAC_W = 16,
    localparam int STEPS = (NUM_W + FRAC_W + 1) / 2,
    localparam int Q_W   = 2 * STEPS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [Q_W-1:0]   quotient
);

    localparam int CNT_W = $clog2(STEPS + 1);

    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [Q_W-1:0]   quo_reg, quo_next;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    always_comb
    begin
        logic [DEN_W:0]   t;
        logic [DEN_W-1:0] r;
        logic [Q_W-1:0]   q;
        r = rem_reg;
        q = quo_reg;
        for (int i = 0; i < 2; i++)
        begin
            t = {r, q[Q_W-1]};
            q = {q[Q_W-2:0], 1'b0};
            if (t >= {1'b0, den_reg})
            begin
                t    = t - {1'b0, den_reg};
                q[0] = 1'b1;
            end
            r = t[DEN_W-1:0];
        end
        rem_next = r;
        quo_next = q;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(STEPS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= Q_W'({num, FRAC_W'(0)});
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* rtl/bir_pixel_ram.sv */
// Single-port source image memory with registered read data.
module bir_pixel_ram #(
    parameter int DEPTH  = 65536,
    parameter int ADDR_W = 16,
    parameter int DATA_W = 8
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [DATA_W-1:0] wdata,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        else
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/bilinear_image_resize_unit.sv */
// Top level of the bilinear image resize unit with align-corners mapping.
//
// Input channel (in_valid/in_ready): func 0 stores pixel_in at (src_row, src_col)
// in the source memory; func 1 asks for the destination pixel (dst_row, dst_col).
// Output channel (out_valid/out_ready): one beat per query, pixel_out and
// out_of_range; a write gives no beat.
// A write keeps the block idle; the next item is taken in the following cycle.
// A query in range goes through the map and divide states, where two dividers
// (one per axis) produce two quotient bits a cycle, then four reads from the
// single-port source memory and three blend steps on one shared blend unit.
// An out-of-range query goes from the map to the finish state with pixel_out 0.
// One query is worked on at a time; the result register holds a finished beat
// while the next item is taken, and a stalled receiver holds back only the
// completion of the following query.
// Reset clears the control state and sets the size registers to 256; the
// source memory is not cleared and must be written before it is read.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once; the
// user must make them only while the block is idle; this is not enforced.
module bilinear_image_resize_unit #(
    parameter int MAX_SRC_WIDTH  = 256,
    parameter int MAX_SRC_HEIGHT = 256,
    parameter int FRAC_BITS      = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [bir_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bir_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               func,
    input  logic [bir_pkg::SCOORD_W-1:0]       src_col,
    input  logic [bir_pkg::SCOORD_W-1:0]       src_row,
    input  logic [bir_pkg::PIX_W-1:0]          pixel_in,
    input  logic [bir_pkg::DCOORD_W-1:0]       dst_col,
    input  logic [bir_pkg::DCOORD_W-1:0]       dst_row,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [bir_pkg::PIX_W-1:0]          pixel_out,
    output logic                               out_of_range
);

    localparam int PIX_W   = bir_pkg::PIX_W;
    localparam int DSIZE_W = bir_pkg::DSIZE_W;
    localparam int SWX_W   = $clog2(MAX_SRC_WIDTH + 1);
    localparam int SWY_W   = $clog2(MAX_SRC_HEIGHT + 1);
    localparam int COL_W   = $clog2(MAX_SRC_WIDTH);
    localparam int ROW_W   = $clog2(MAX_SRC_HEIGHT);
    localparam int DEPTH   = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int NUMX_W  = bir_pkg::DCOORD_W + ((SWX_W > SWY_W) ? SWX_W : SWY_W);
    localparam int NUMY_W  = NUMX_W;
    localparam int QX_W    = 2 * ((NUMX_W + FRAC_BITS + 1) / 2);
    localparam int QY_W    = 2 * ((NUMY_W + FRAC_BITS + 1) / 2);
    localparam int IPX_W   = QX_W - FRAC_BITS;
    localparam int IPY_W   = QY_W - FRAC_BITS;
    localparam int BL_W    = PIX_W + FRAC_BITS;
    localparam int V_W     = PIX_W + 2 * FRAC_BITS;

    bir_pkg::state_t state_reg, state_next;

    logic [bir_pkg::SSIZE_W-1:0] src_width_reg, src_height_reg;
    logic [DSIZE_W-1:0]          dst_width_reg, dst_height_reg;

    logic [bir_pkg::DCOORD_W-1:0] dc_reg, dr_reg;
    logic                         oor_reg;
    logic [COL_W-1:0]             x0_reg, x1_reg;
    logic [ROW_W-1:0]             y0_reg, y1_reg;
    logic [FRAC_BITS-1:0]         fx_reg, fy_reg;
    logic [PIX_W-1:0]             v00_reg, v10_reg, v01_reg, v11_reg;
    logic [BL_W-1:0]              h0_reg, h1_reg;
    logic [V_W-1:0]               v_reg;

    logic                         out_valid_reg;
    logic [PIX_W-1:0]             pixel_out_reg;
    logic                         oor_out_reg;

    logic [SWX_W-1:0] swx, smx;
    logic [SWY_W-1:0] swy, smy;
    logic             in_beat, wr_ok, query_oor, out_free;

    bir_pkg::div_ctrl_t div_x, div_y;
    logic [QX_W-1:0]    qx;
    logic [QY_W-1:0]    qy;

    logic [ADDR_W-1:0] ram_addr;
    logic              ram_we;
    logic [PIX_W-1:0]  ram_rdata;

    logic [IPX_W-1:0]     ipx;
    logic [IPY_W-1:0]     ipy;
    logic [COL_W-1:0]     x0_c;
    logic [ROW_W-1:0]     y0_c;
    logic [SWX_W-1:0]     x0_inc;
    logic [SWY_W-1:0]     y0_inc;

    logic [BL_W-1:0]      bl_a, bl_b;
    logic [FRAC_BITS-1:0] bl_f;
    logic [BL_W+FRAC_BITS:0] bl_sum;
    logic [V_W:0]         rnd_sum;
    logic [V_W-2*FRAC_BITS:0] rnd_res;
    logic [PIX_W-1:0]     res_sat;

    assign in_ready = (state_reg == bir_pkg::S_IDLE);
    assign in_beat  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign wr_ok    = (32'(src_col) < 32'(MAX_SRC_WIDTH))
                   && (32'(src_row) < 32'(MAX_SRC_HEIGHT));

    always_comb
    begin
        if (32'(src_width_reg) > 32'(MAX_SRC_WIDTH))
            swx = SWX_W'(MAX_SRC_WIDTH);
        else if (src_width_reg == '0)
            swx = SWX_W'(1);
        else
            swx = SWX_W'(src_width_reg);
        if (32'(src_height_reg) > 32'(MAX_SRC_HEIGHT))
            swy = SWY_W'(MAX_SRC_HEIGHT);
        else if (src_height_reg == '0)
            swy = SWY_W'(1);
        else
            swy = SWY_W'(src_height_reg);
        smx = swx - 1'b1;
        smy = swy - 1'b1;
    end

    assign query_oor = ({1'b0, dc_reg} >= dst_width_reg)
                    || ({1'b0, dr_reg} >= dst_height_reg);

    assign div_x.start = (state_reg == bir_pkg::S_MAP) && !query_oor;
    assign div_y.start = div_x.start;

    bir_divider #(
        .NUM_W  (NUMX_W),
        .DEN_W  (DSIZE_W),
        .FRAC_W (FRAC_BITS)
    ) u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_x.start),
        .num      (NUMX_W'(dc_reg) * NUMX_W'(smx)),
        .den      (dst_width_reg - 1'b1),
        .done     (div_x.done),
        .quotient (qx)
    );

    bir_divider #(
        .NUM_W  (NUMY_W),
        .DEN_W  (DSIZE_W),
        .FRAC_W (FRAC_BITS)
    ) u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_y.start),
        .num      (NUMY_W'(dr_reg) * NUMY_W'(smy)),
        .den      (dst_height_reg - 1'b1),
        .done     (div_y.done),
        .quotient (qy)
    );

    // integer parts, clamped to the last column and row
    always_comb
    begin
        ipx = (dst_width_reg <= DSIZE_W'(1)) ? '0 : qx[QX_W-1:FRAC_BITS];
        ipy = (dst_height_reg <= DSIZE_W'(1)) ? '0 : qy[QY_W-1:FRAC_BITS];
        x0_c = (ipx > IPX_W'(smx)) ? COL_W'(smx) : COL_W'(ipx);
        y0_c = (ipy > IPY_W'(smy)) ? ROW_W'(smy) : ROW_W'(ipy);
        x0_inc = SWX_W'(x0_c) + 1'b1;
        y0_inc = SWY_W'(y0_c) + 1'b1;
    end

    always_comb
    begin
        ram_we   = 1'b0;
        ram_addr = ADDR_W'(y0_reg) * ADDR_W'(MAX_SRC_WIDTH) + ADDR_W'(x0_reg);
        case (state_reg)
            bir_pkg::S_IDLE:
            begin
                ram_we   = in_beat && (func == bir_pkg::FUNC_WRITE) && wr_ok;
                ram_addr = ADDR_W'(src_row) * ADDR_W'(MAX_SRC_WIDTH) + ADDR_W'(src_col);
            end
            bir_pkg::S_RD1:
                ram_addr = ADDR_W'(y0_reg) * ADDR_W'(MAX_SRC_WIDTH) + ADDR_W'(x1_reg);
            bir_pkg::S_RD2:
                ram_addr = ADDR_W'(y1_reg) * ADDR_W'(MAX_SRC_WIDTH) + ADDR_W'(x0_reg);
            bir_pkg::S_RD3:
                ram_addr = ADDR_W'(y1_reg) * ADDR_W'(MAX_SRC_WIDTH) + ADDR_W'(x1_reg);
            default:
                ram_addr = ADDR_W'(y0_reg) * ADDR_W'(MAX_SRC_WIDTH) + ADDR_W'(x0_reg);
        endcase
    end

    bir_pixel_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (PIX_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (pixel_in),
        .rdata (ram_rdata)
    );

    // shared blend a*(1-f) + b*f
    always_comb
    begin
        case (state_reg)
            bir_pkg::S_BLH0:
            begin
                bl_a = BL_W'(v00_reg);
                bl_b = BL_W'(v10_reg);
                bl_f = fx_reg;
            end
            bir_pkg::S_BLH1:
            begin
                bl_a = BL_W'(v01_reg);
                bl_b = BL_W'(v11_reg);
                bl_f = fx_reg;
            end
            default:
            begin
                bl_a = h0_reg;
                bl_b = h1_reg;
                bl_f = fy_reg;
            end
        endcase
        bl_sum = (BL_W+FRAC_BITS+1)'(bl_a)
                 * (BL_W+FRAC_BITS+1)'({1'b1, FRAC_BITS'(0)} - {1'b0, bl_f})
               + (BL_W+FRAC_BITS+1)'(bl_b) * (BL_W+FRAC_BITS+1)'(bl_f);
    end

    always_comb
    begin
        rnd_sum = (V_W+1)'(v_reg) + ((V_W+1)'(1) << (2 * FRAC_BITS - 1));
        rnd_res = rnd_sum[V_W:2*FRAC_BITS];
        res_sat = (rnd_res > (V_W-2*FRAC_BITS+1)'(255)) ? PIX_W'(255) : PIX_W'(rnd_res);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bir_pkg::S_IDLE:
                if (in_beat && (func == bir_pkg::FUNC_QUERY))
                    state_next = bir_pkg::S_MAP;
            bir_pkg::S_MAP:
                state_next = query_oor ? bir_pkg::S_FIN : bir_pkg::S_DIV;
            bir_pkg::S_DIV:
                if (div_x.done && div_y.done)
                    state_next = bir_pkg::S_RD0;
            bir_pkg::S_RD0:  state_next = bir_pkg::S_RD1;
            bir_pkg::S_RD1:  state_next = bir_pkg::S_RD2;
            bir_pkg::S_RD2:  state_next = bir_pkg::S_RD3;
            bir_pkg::S_RD3:  state_next = bir_pkg::S_RD4;
            bir_pkg::S_RD4:  state_next = bir_pkg::S_BLH0;
            bir_pkg::S_BLH0: state_next = bir_pkg::S_BLH1;
            bir_pkg::S_BLH1: state_next = bir_pkg::S_BLV;
            bir_pkg::S_BLV:  state_next = bir_pkg::S_FIN;
            bir_pkg::S_FIN:
                if (out_free)
                    state_next = bir_pkg::S_IDLE;
            default:
                state_next = bir_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= bir_pkg::S_IDLE;
            src_width_reg  <= bir_pkg::SSIZE_RESET;
            src_height_reg <= bir_pkg::SSIZE_RESET;
            dst_width_reg  <= bir_pkg::DSIZE_RESET;
            dst_height_reg <= bir_pkg::DSIZE_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    bir_pkg::CFG_SRC_WIDTH:  src_width_reg  <= cfg_data[bir_pkg::SSIZE_W-1:0];
                    bir_pkg::CFG_SRC_HEIGHT: src_height_reg <= cfg_data[bir_pkg::SSIZE_W-1:0];
                    bir_pkg::CFG_DST_WIDTH:  dst_width_reg  <= cfg_data[DSIZE_W-1:0];
                    bir_pkg::CFG_DST_HEIGHT: dst_height_reg <= cfg_data[DSIZE_W-1:0];
                    default: ;
                endcase
            end
            if ((state_reg == bir_pkg::S_FIN) && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            dc_reg <= dst_col;
            dr_reg <= dst_row;
        end
        if (state_reg == bir_pkg::S_MAP)
            oor_reg <= query_oor;
        if ((state_reg == bir_pkg::S_DIV) && div_x.done && div_y.done)
        begin
            x0_reg <= x0_c;
            y0_reg <= y0_c;
            x1_reg <= (x0_inc < swx) ? COL_W'(x0_inc) : COL_W'(smx);
            y1_reg <= (y0_inc < swy) ? ROW_W'(y0_inc) : ROW_W'(smy);
            fx_reg <= (dst_width_reg <= DSIZE_W'(1)) ? '0 : qx[FRAC_BITS-1:0];
            fy_reg <= (dst_height_reg <= DSIZE_W'(1)) ? '0 : qy[FRAC_BITS-1:0];
        end
        if (state_reg == bir_pkg::S_RD1) v00_reg <= ram_rdata;
        if (state_reg == bir_pkg::S_RD2) v10_reg <= ram_rdata;
        if (state_reg == bir_pkg::S_RD3) v01_reg <= ram_rdata;
        if (state_reg == bir_pkg::S_RD4) v11_reg <= ram_rdata;
        if (state_reg == bir_pkg::S_BLH0) h0_reg <= bl_sum[BL_W-1:0];
        if (state_reg == bir_pkg::S_BLH1) h1_reg <= bl_sum[BL_W-1:0];
        if (state_reg == bir_pkg::S_BLV)  v_reg  <= V_W'(bl_sum);
        if ((state_reg == bir_pkg::S_FIN) && out_free)
        begin
            pixel_out_reg <= oor_reg ? '0 : res_sat;
            oor_out_reg   <= oor_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign pixel_out    = pixel_out_reg;
    assign out_of_range = oor_out_reg;

endmodule

/* rtl/bir_checker.sv */
// Port-level checks of the bilinear resize unit and their bind to the top level.
module bir_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic                           func,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [bir_pkg::PIX_W-1:0]      pixel_out,
    input logic                           out_of_range
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pixel_out) && $stable(out_of_range))
        else $error("result beat changed while stalled");

    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_of_range |-> pixel_out == '0)
        else $error("out-of-range result carries a nonzero pixel");

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (func == bir_pkg::FUNC_QUERY) |=> !in_ready)
        else $error("input taken while a query is in progress");

    a_write_fast: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (func == bir_pkg::FUNC_WRITE) |=> in_ready)
        else $error("write beat stalled the input");

endmodule

bind bilinear_image_resize_unit bir_checker u_bir_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .func         (func),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pixel_out    (pixel_out),
    .out_of_range (out_of_range)
);

/* sim/tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the bilinear resize unit with a shadow image and result scoreboard.
module tb;

    localparam int CLK_HALF      = 5;
    localparam int STORE_DIM     = 256;
    localparam int FRAC          = 16;
    localparam int SETTLE_CYCLES = 40;
    localparam int STALL_LIMIT   = 20000;
    localparam int HOLD_CYCLES   = 600;
    localparam int REPORT_MAX    = 10;

    typedef struct packed {
        logic [bir_pkg::PIX_W-1:0] pixel;
        logic                      oor;
    } resize_result_t;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [bir_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [bir_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                           in_valid;
    logic                           in_ready;
    logic                           func;
    logic [bir_pkg::SCOORD_W-1:0]   src_col;
    logic [bir_pkg::SCOORD_W-1:0]   src_row;
    logic [bir_pkg::PIX_W-1:0]      pixel_in;
    logic [bir_pkg::DCOORD_W-1:0]   dst_col;
    logic [bir_pkg::DCOORD_W-1:0]   dst_row;
    logic                           out_valid;
    logic                           out_ready;
    logic [bir_pkg::PIX_W-1:0]      pixel_out;
    logic                           out_of_range;

    bilinear_image_resize_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .src_col      (src_col),
        .src_row      (src_row),
        .pixel_in     (pixel_in),
        .dst_col      (dst_col),
        .dst_row      (dst_row),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pixel_out    (pixel_out),
        .out_of_range (out_of_range)
    );

    resize_result_t              pending_results[$];
    logic [bir_pkg::PIX_W-1:0]   shadow_image [STORE_DIM][STORE_DIM];
    bit                          pixel_written [STORE_DIM][STORE_DIM];
    logic [bir_pkg::SSIZE_W-1:0] src_w_reg;
    logic [bir_pkg::SSIZE_W-1:0] src_h_reg;
    logic [bir_pkg::DSIZE_W-1:0] dst_w_reg;
    logic [bir_pkg::DSIZE_W-1:0] dst_h_reg;

    int send_idle_pct;
    int recv_stall_pct;
    bit hold_request;
    int items_sent;
    int writes_sent;
    int queries_sent;
    int oor_sent;
    int results_checked;
    int mismatches;
    int quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    function automatic int unsigned eff_size(int unsigned v);
        if (v < 1)
        begin
            return 1;
        end
        if (v > STORE_DIM)
        begin
            return STORE_DIM;
        end
        return v;
    endfunction

    function automatic void locate_axis(input int unsigned d, input int unsigned size_reg,
                                        input int unsigned dsize, output int unsigned lo,
                                        output int unsigned hi, output longint unsigned frac);
        longint unsigned num;
        longint unsigned den;
        int unsigned     s;
        s = eff_size(size_reg);
        if (dsize <= 1)
        begin
            lo = 0;
            frac = '0;
        end
        else
        begin
            num = 64'(d);
            num = num * 64'(s - 1);
            den = 64'(dsize - 1);
            lo = int'(num / den);
            frac = ((num % den) << FRAC) / den;
        end
        if (lo > s - 1)
        begin
            lo = s - 1;
        end
        hi = (lo + 1 < s) ? lo + 1 : s - 1;
    endfunction

    function automatic resize_result_t predict_resize(int unsigned dc, int unsigned dr);
        resize_result_t  r;
        int unsigned     x0, x1, y0, y1;
        longint unsigned fx, fy, one, v00, v10, v01, v11, h0, h1, acc, sum;
        if (dc >= dst_w_reg || dr >= dst_h_reg)
        begin
            r.pixel = '0;
            r.oor = 1'b1;
            return r;
        end
        locate_axis(dc, 32'(src_w_reg), 32'(dst_w_reg), x0, x1, fx);
        locate_axis(dr, 32'(src_h_reg), 32'(dst_h_reg), y0, y1, fy);
        one = 64'd1 << FRAC;
        v00 = 64'(shadow_image[y0][x0]);
        v10 = 64'(shadow_image[y0][x1]);
        v01 = 64'(shadow_image[y1][x0]);
        v11 = 64'(shadow_image[y1][x1]);
        h0 = v00 * (one - fx) + v10 * fx;
        h1 = v01 * (one - fx) + v11 * fx;
        acc = h0 * (one - fy) + h1 * fy;
        sum = (acc + (64'd1 << (2 * FRAC - 1))) >> (2 * FRAC);
        r.pixel = (sum > 255) ? 8'd255 : sum[7:0];
        r.oor = 1'b0;
        return r;
    endfunction

    function automatic logic [bir_pkg::PIX_W-1:0] rand_pixel();
        case ($urandom_range(7))
            0: return 8'd0;
            1: return 8'd255;
            default: return bir_pkg::PIX_W'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [bir_pkg::DCOORD_W-1:0] pick_coord(int unsigned dsize);
        int unsigned lim;
        lim = (dsize > 1024) ? 1024 : dsize;
        case ($urandom_range(7))
            0: return '0;
            1: return bir_pkg::DCOORD_W'(lim - 1);
            default: return bir_pkg::DCOORD_W'($urandom_range(lim - 1));
        endcase
    endfunction

    task automatic cfg_write(logic [bir_pkg::CFG_IDX_W-1:0] idx, int unsigned value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[bir_pkg::CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            bir_pkg::CFG_SRC_WIDTH:  src_w_reg = value[bir_pkg::SSIZE_W-1:0];
            bir_pkg::CFG_SRC_HEIGHT: src_h_reg = value[bir_pkg::SSIZE_W-1:0];
            bir_pkg::CFG_DST_WIDTH:  dst_w_reg = value[bir_pkg::DSIZE_W-1:0];
            bir_pkg::CFG_DST_HEIGHT: dst_h_reg = value[bir_pkg::DSIZE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_sizes(int unsigned sw, int unsigned sh, int unsigned dw, int unsigned dh);
        settle();
        cfg_write(bir_pkg::CFG_SRC_WIDTH, sw);
        cfg_write(bir_pkg::CFG_SRC_HEIGHT, sh);
        cfg_write(bir_pkg::CFG_DST_WIDTH, dw);
        cfg_write(bir_pkg::CFG_DST_HEIGHT, dh);
    endtask

    task automatic send_item(logic f, logic [bir_pkg::SCOORD_W-1:0] sc,
                             logic [bir_pkg::SCOORD_W-1:0] sr,
                             logic [bir_pkg::PIX_W-1:0] px, logic [bir_pkg::DCOORD_W-1:0] dc,
                             logic [bir_pkg::DCOORD_W-1:0] dr);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= f;
        src_col <= sc;
        src_row <= sr;
        pixel_in <= px;
        dst_col <= dc;
        dst_row <= dr;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        items_sent++;
        if (f == bir_pkg::FUNC_WRITE)
        begin
            shadow_image[sr][sc] = px;
            pixel_written[sr][sc] = 1'b1;
            writes_sent++;
        end
        else
        begin
            pending_results.push_back(predict_resize(32'(dc), 32'(dr)));
            queries_sent++;
        end
    endtask

    task automatic fill_pixel(int unsigned row, int unsigned col);
        if (!pixel_written[row][col])
        begin
            send_item(bir_pkg::FUNC_WRITE, bir_pkg::SCOORD_W'(col), bir_pkg::SCOORD_W'(row),
                      rand_pixel(), bir_pkg::DCOORD_W'($urandom_range(1023)),
                      bir_pkg::DCOORD_W'($urandom_range(1023)));
        end
    endtask

    task automatic send_query(logic [bir_pkg::DCOORD_W-1:0] dc,
                              logic [bir_pkg::DCOORD_W-1:0] dr);
        int unsigned     x0, x1, y0, y1;
        longint unsigned fx, fy;
        if (dc < dst_w_reg && dr < dst_h_reg)
        begin
            locate_axis(32'(dc), 32'(src_w_reg), 32'(dst_w_reg), x0, x1, fx);
            locate_axis(32'(dr), 32'(src_h_reg), 32'(dst_h_reg), y0, y1, fy);
            fill_pixel(y0, x0);
            fill_pixel(y0, x1);
            fill_pixel(y1, x0);
            fill_pixel(y1, x1);
        end
        else
        begin
            oor_sent++;
        end
        send_item(bir_pkg::FUNC_QUERY, bir_pkg::SCOORD_W'($urandom_range(255)),
                  bir_pkg::SCOORD_W'($urandom_range(255)), rand_pixel(), dc, dr);
    endtask

    task automatic send_outside_query();
        if (dst_w_reg <= 1023)
        begin
            send_query(bir_pkg::DCOORD_W'($urandom_range(1023, dst_w_reg)),
                       bir_pkg::DCOORD_W'($urandom_range(1023)));
        end
        else if (dst_h_reg <= 1023)
        begin
            send_query(bir_pkg::DCOORD_W'($urandom_range(1023)),
                       bir_pkg::DCOORD_W'($urandom_range(1023, dst_h_reg)));
        end
        else
        begin
            send_query(pick_coord(32'(dst_w_reg)), pick_coord(32'(dst_h_reg)));
        end
    endtask

    task automatic test_directed();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_item(bir_pkg::FUNC_WRITE, 8'd0, 8'd0, 8'd0, 10'd1023, 10'd1023);
        send_item(bir_pkg::FUNC_WRITE, 8'd1, 8'd0, 8'd255, 10'd0, 10'd0);
        send_item(bir_pkg::FUNC_WRITE, 8'd0, 8'd1, 8'd255, 10'd0, 10'd0);
        send_item(bir_pkg::FUNC_WRITE, 8'd1, 8'd1, 8'd0, 10'd0, 10'd0);
        send_query(10'd0, 10'd0);
        send_query(10'd1, 10'd0);
        send_query(10'd255, 10'd255);
        send_query(10'd256, 10'd0);
        send_query(10'd0, 10'd256);
        send_query(10'd1023, 10'd1023);
        // halfway between 0 and 255 on both axes: rounds up
        set_sizes(2, 2, 3, 3);
        send_query(10'd1, 10'd1);
        send_query(10'd2, 10'd2);
        send_query(10'd1, 10'd0);
        send_query(10'd3, 10'd0);
        set_sizes(1, 1, 1, 1);
        send_query(10'd0, 10'd0);
        send_query(10'd1, 10'd0);
        set_sizes(2, 2, 0, 0);
        send_query(10'd0, 10'd0);
    endtask

    task automatic test_random_mix(int unsigned sw, int unsigned sh, int unsigned dw,
                                   int unsigned dh, int idle_pct, int stall_pct, int n_items);
        int stop_at;
        int sel;
        set_sizes(sw, sh, dw, dh);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at)
        begin
            sel = $urandom_range(99);
            if (sel < 10)
            begin
                send_item(bir_pkg::FUNC_WRITE, bir_pkg::SCOORD_W'($urandom_range(255)),
                          bir_pkg::SCOORD_W'($urandom_range(255)), rand_pixel(),
                          bir_pkg::DCOORD_W'($urandom_range(1023)),
                          bir_pkg::DCOORD_W'($urandom_range(1023)));
            end
            else if (sel < 22 || dst_w_reg == 0 || dst_h_reg == 0)
            begin
                send_outside_query();
            end
            else
            begin
                send_query(pick_coord(32'(dst_w_reg)), pick_coord(32'(dst_h_reg)));
            end
        end
    endtask

    task automatic test_backpressure();
        set_sizes(12, 9, 40, 25);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_request = 1'b1;
        repeat (40) send_query(pick_coord(32'(dst_w_reg)), pick_coord(32'(dst_h_reg)));
    endtask

    initial
    begin
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= bir_pkg::CFG_SRC_WIDTH;
        cfg_data <= '0;
        in_valid <= 1'b0;
        func <= bir_pkg::FUNC_WRITE;
        src_col <= '0;
        src_row <= '0;
        pixel_in <= '0;
        dst_col <= '0;
        dst_row <= '0;
        src_w_reg = bir_pkg::SSIZE_RESET;
        src_h_reg = bir_pkg::SSIZE_RESET;
        dst_w_reg = bir_pkg::DSIZE_RESET;
        dst_h_reg = bir_pkg::DSIZE_RESET;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_request = 1'b0;
        items_sent = 0;
        writes_sent = 0;
        queries_sent = 0;
        oor_sent = 0;
        results_checked = 0;
        mismatches = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random_mix(256, 256, 1024, 1024, 0, 0, 140);
        test_random_mix(7, 5, 20, 13, 80, 0, 130);
        test_random_mix(1, 1, 9, 1, 0, 80, 110);
        test_random_mix(0, 511, 2047, 600, 32, 32, 140);
        test_random_mix(300, 2, 1, 1023, 0, 0, 120);
        test_random_mix(16, 16, 0, 5, 80, 0, 40);
        test_backpressure();
        test_random_mix(256, 3, 255, 1024, 0, 80, 130);
        test_random_mix(33, 64, 97, 31, 32, 32, 140);
        test_random_mix(2, 256, 2, 1024, 0, 0, 60);
        settle();

        $display("covered %0d items: %0d pixel writes, %0d queries (%0d outside the destination)",
                 items_sent, writes_sent, queries_sent, oor_sent);
        $display("%0d results checked over fourteen size settings and four idle patterns, %0d %s",
                 results_checked, mismatches, "mismatches");
        if (mismatches == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial
    begin
        int             hold_left;
        resize_result_t want;
        hold_left = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                    begin
                        $display("unexpected beat: pixel_out %0d out_of_range %0b",
                                 pixel_out, out_of_range);
                    end
                end
                else
                begin
                    want = pending_results.pop_front();
                    results_checked++;
                    if (pixel_out !== want.pixel || out_of_range !== want.oor)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                        begin
                            $display("mismatch: expected pixel %0d oor %0b, got pixel %0d oor %0b",
                                     want.pixel, want.oor, pixel_out, out_of_range);
                        end
                    end
                end
            end
            // hold off the receiver so the block backs up
            if (hold_request)
            begin
                hold_left = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    initial
    begin
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no beat moved for %0d cycles", STALL_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

endmodule

/* files.f */
rtl/bir_pkg.sv
rtl/bir_divider.sv
rtl/bir_pixel_ram.sv
rtl/bilinear_image_resize_unit.sv
rtl/bir_checker.sv
sim/tb.sv
